// File: src/wam_pkg.sv
// Shared types and constants for the weekday alarm matcher.
// Holds the payload structs, the item mode codes and the weekday mask helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wam_pkg;

  localparam int ALARM_COUNT = 8;
  localparam int CMP_W       = 5;   // wide enough to compare indexes up to the largest table

  localparam int STAMP_W = 27;
  localparam logic [STAMP_W-1:0] STAMP_NEVER = '1;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  localparam logic [15:0] SNOOZE_RESET = 16'd300;

  // now / 60 == (now >> 2) / 15; ceil(2^34 / 15) is exact for 30-bit operands
  localparam int          RECIP_SHIFT = 34;
  localparam logic [30:0] RECIP_15    = 31'd1145324613;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SNOOZE  = 2'd1,
    MODE_DISMISS = 2'd2,
    MODE_CONFIG  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] epoch_sec;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [2:0]  day_of_week;
    logic [2:0]  entry_sel;
    logic        set_enabled;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic        set_one_time;
    logic [6:0]  set_weekdays;
  } wam_in_t;

  typedef struct packed {
    logic       due_valid;
    logic [2:0] due_index;
    logic       save_request;
    logic       accepted;
    logic       indicator_active;
  } wam_out_t;

  // Sunday-first weekday number to Monday-first mask bit; seven folds onto Sunday
  function automatic logic [6:0] day_mask(input logic [2:0] dow);
    logic [6:0] m;
    case (dow)
      3'd0:    m = 7'b100_0000;
      3'd1:    m = 7'b000_0001;
      3'd2:    m = 7'b000_0010;
      3'd3:    m = 7'b000_0100;
      3'd4:    m = 7'b000_1000;
      3'd5:    m = 7'b001_0000;
      3'd6:    m = 7'b010_0000;
      default: m = 7'b100_0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: src/weekday_alarm_matcher_with_snooze.sv
// Top level of the weekday alarm matcher with snooze.
// Uses wam_pkg for payload structs, mode codes and constants.
// Alarm table, snooze state and result register live here.
`timescale 1ns / 1ps
`default_nettype none

// Every item (tick, snooze, dismiss, configure) yields exactly one result, in the
// cycle after its transfer, from a single registered pass: all alarm entries
// compare in parallel against the tick time, and the minute stamp comes from
// one 30x31 multiply by a reciprocal of 15. A new item is taken every cycle
// while the result register is free or being drained; in_stall rises only
// when a finished result is held by out_stall. The snooze length register is
// written through cfg_wr_en / cfg_wr_data and resets to 300 seconds.
module weekday_alarm_matcher_with_snooze (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [15:0]      cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire wam_pkg::wam_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output wam_pkg::wam_out_t     out_data
);

  localparam int N = wam_pkg::ALARM_COUNT;

  logic [15:0] snooze_sec_r;

  logic                        en_r    [N];
  logic [4:0]                  hour_r  [N];
  logic [5:0]                  min_r   [N];
  logic                        once_r  [N];
  logic [6:0]                  days_r  [N];
  logic [wam_pkg::STAMP_W-1:0] stamp_r [N];

  logic                        en_nxt    [N];
  logic [4:0]                  hour_nxt  [N];
  logic [5:0]                  min_nxt   [N];
  logic                        once_nxt  [N];
  logic [6:0]                  days_nxt  [N];
  logic [wam_pkg::STAMP_W-1:0] stamp_nxt [N];

  logic        snz_pend_r, snz_pend_nxt;
  logic [2:0]  snz_entry_r, snz_entry_nxt;
  logic [31:0] snz_dead_r, snz_dead_nxt;

  logic              out_valid_r, out_valid_nxt;
  wam_pkg::wam_out_t out_r, out_nxt;

  logic        accept;
  logic [60:0] prod;
  logic [wam_pkg::STAMP_W-1:0] stamp_now;
  logic [6:0]  dbit;
  logic [N-1:0] hit;
  logic [N-1:0] sel;
  logic        idx_ok;
  logic        cfg_ok;
  logic        snz_due;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign prod      = 61'(in_data.epoch_sec[31:2]) * 61'(wam_pkg::RECIP_15);
  assign stamp_now = prod[wam_pkg::RECIP_SHIFT +: wam_pkg::STAMP_W];
  assign dbit      = wam_pkg::day_mask(in_data.day_of_week);
  assign snz_due   = snz_pend_r && (in_data.epoch_sec >= snz_dead_r);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel[i] = (wam_pkg::CMP_W'(in_data.entry_sel) == wam_pkg::CMP_W'(i));
      hit[i] = en_r[i] && (hour_r[i] == in_data.now_hour) &&
               (min_r[i] == in_data.now_minute) &&
               (once_r[i] || ((days_r[i] & dbit) != 7'd0)) &&
               (stamp_r[i] != stamp_now);
    end
  end

  assign idx_ok = |sel;
  assign cfg_ok = idx_ok && (in_data.set_hour <= wam_pkg::HOUR_MAX) &&
                  (in_data.set_minute <= wam_pkg::MINUTE_MAX);

  always_comb begin
    logic found;
    logic any_en;
    found         = 1'b0;
    any_en        = 1'b0;
    en_nxt        = en_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    once_nxt      = once_r;
    days_nxt      = days_r;
    stamp_nxt     = stamp_r;
    snz_pend_nxt  = snz_pend_r;
    snz_entry_nxt = snz_entry_r;
    snz_dead_nxt  = snz_dead_r;
    out_nxt       = out_r;
    out_nxt.due_valid    = 1'b0;
    out_nxt.due_index    = 3'd0;
    out_nxt.save_request = 1'b0;
    out_nxt.accepted     = 1'b1;

    case (in_data.mode)
      wam_pkg::MODE_TICK: begin
        if (snz_due) begin
          out_nxt.due_valid = 1'b1;
          out_nxt.due_index = snz_entry_r;
          snz_pend_nxt      = 1'b0;
          snz_entry_nxt     = 3'd0;
          snz_dead_nxt      = 32'd0;
        end else begin
          for (int i = 0; i < N; i++) begin
            if (hit[i]) begin
              stamp_nxt[i] = stamp_now;
              if (once_r[i]) begin
                en_nxt[i]            = 1'b0;
                out_nxt.save_request = 1'b1;
              end
              if (!found) begin
                found             = 1'b1;
                out_nxt.due_valid = 1'b1;
                out_nxt.due_index = 3'(i);
              end
            end
          end
        end
      end
      wam_pkg::MODE_SNOOZE: begin
        if (idx_ok) begin
          snz_pend_nxt  = 1'b1;
          snz_entry_nxt = in_data.entry_sel;
          snz_dead_nxt  = in_data.epoch_sec + {16'd0, snooze_sec_r};
        end
      end
      wam_pkg::MODE_DISMISS: begin
        snz_pend_nxt  = 1'b0;
        snz_entry_nxt = 3'd0;
        snz_dead_nxt  = 32'd0;
      end
      wam_pkg::MODE_CONFIG: begin
        if (cfg_ok) begin
          for (int i = 0; i < N; i++) begin
            if (sel[i]) begin
              en_nxt[i]    = in_data.set_enabled;
              hour_nxt[i]  = in_data.set_hour;
              min_nxt[i]   = in_data.set_minute;
              once_nxt[i]  = in_data.set_one_time;
              days_nxt[i]  = in_data.set_weekdays;
              stamp_nxt[i] = wam_pkg::STAMP_NEVER;
            end
          end
          // drop the snooze only when its own entry gets disabled
          if (snz_pend_r && (snz_entry_r == in_data.entry_sel) && !in_data.set_enabled) begin
            snz_pend_nxt = 1'b0;
          end
          out_nxt.save_request = 1'b1;
        end else begin
          out_nxt.accepted = 1'b0;
        end
      end
      default: begin
        out_nxt.accepted = 1'b1;
      end
    endcase

    for (int i = 0; i < N; i++) begin
      any_en = any_en | en_nxt[i];
    end
    out_nxt.indicator_active = snz_pend_nxt || any_en;
  end

  // hold a stalled result, load a new one on every input transfer
  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snooze_sec_r <= wam_pkg::SNOOZE_RESET;
      out_valid_r  <= 1'b0;
      snz_pend_r   <= 1'b0;
      snz_entry_r  <= 3'd0;
      snz_dead_r   <= 32'd0;
      for (int i = 0; i < N; i++) begin
        en_r[i]    <= 1'b0;
        stamp_r[i] <= wam_pkg::STAMP_NEVER;
      end
    end else begin
      if (cfg_wr_en) begin
        snooze_sec_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        snz_pend_r  <= snz_pend_nxt;
        snz_entry_r <= snz_entry_nxt;
        snz_dead_r  <= snz_dead_nxt;
        en_r        <= en_nxt;
        stamp_r     <= stamp_nxt;
      end
    end
  end

  // table settings and result payload carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
      once_r <= once_nxt;
      days_r <= days_nxt;
      out_r  <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/wam_checker.sv
// Port-level checks for the weekday alarm matcher.
// Uses wam_pkg for the payload structs; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none

module wam_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire wam_pkg::wam_out_t out_data
);

  // every input transfer shows up as a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("transfer without a result");

  // a rejected configure reports nothing and requests no save
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> !out_data.due_valid && !out_data.save_request)
    else $error("rejected item with side results");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.due_valid |-> out_data.due_index == 3'd0)
    else $error("due index set without due alarm");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind weekday_alarm_matcher_with_snooze wam_checker u_wam_checker (.*);

`default_nettype wire
